// ----- rtl/core/lrast_pkg.sv -----
// ----------------------------------------------------------------------------
// lrast_pkg
// Shared widths and constants of the range assign / range sum block.
// ----------------------------------------------------------------------------
package lrast_pkg;
	localparam int INDEX_BITS = 10;
	localparam int LEAF_BITS = 11;
	localparam int FIELD_VALUE_BITS = 32;
	localparam int SUM_BITS = 42;
	localparam logic REQ_ASSIGN = 1'b0;
	localparam logic REQ_QUERY = 1'b1;
endpackage

// ----- rtl/core/lrast_ifs.sv -----
// ----------------------------------------------------------------------------
// lrast interfaces
// Valid/ready channels for requests, results and the leaf count register.
// ----------------------------------------------------------------------------
interface lrast_req_if import lrast_pkg::*; ();
	logic valid;
	logic ready;
	logic req_type;
	logic [INDEX_BITS-1:0] range_left;
	logic [INDEX_BITS-1:0] range_right;
	logic [FIELD_VALUE_BITS-1:0] assign_value;
	modport source (output valid, req_type, range_left, range_right, assign_value,
		input ready);
	modport sink (input valid, req_type, range_left, range_right, assign_value,
		output ready);
endinterface

interface lrast_rsp_if import lrast_pkg::*; ();
	logic valid;
	logic ready;
	logic [SUM_BITS-1:0] range_sum;
	modport source (output valid, range_sum, input ready);
	modport sink (input valid, range_sum, output ready);
endinterface

interface lrast_cfg_if import lrast_pkg::*; ();
	logic valid;
	logic ready;
	logic [LEAF_BITS-1:0] leaf_count;
	modport source (output valid, leaf_count, input ready);
	modport sink (input valid, leaf_count, output ready);
endinterface

// ----- rtl/core/lrast_mem.sv -----
// ----------------------------------------------------------------------------
// lrast_mem
// Element store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lrast_mem #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- rtl/core/lrast_seq.sv -----
// ----------------------------------------------------------------------------
// lrast_seq
// Sequencer: sweeps the element store one index a cycle, writing on assign,
// summing through one shared adder on query, clearing after reset/config.
// ----------------------------------------------------------------------------
module lrast_seq import lrast_pkg::*; #(
	parameter int MAX_ELEMENTS = 1024,
	parameter int VALUE_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	lrast_req_if.sink                       req,
	lrast_rsp_if.source                     rsp,
	lrast_cfg_if.sink                       cfg,
	output logic                            mem_we,
	output logic [$clog2(MAX_ELEMENTS)-1:0] mem_addr,
	output logic [VALUE_BITS-1:0]           mem_wdata,
	input  logic [VALUE_BITS-1:0]           mem_rdata
);
	localparam int AW = $clog2(MAX_ELEMENTS);
	localparam int CW = $clog2(MAX_ELEMENTS + 1);
	localparam int KW = (CW > LEAF_BITS) ? CW : LEAF_BITS;
	localparam int EW = (VALUE_BITS > SUM_BITS) ? VALUE_BITS : SUM_BITS;
	localparam logic [KW-1:0] MAX_K = KW'(MAX_ELEMENTS);

	typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_ASSIGN, ST_QUERY, ST_DRAIN, ST_DONE}
		state_t;

	state_t                state_q;
	logic [LEAF_BITS-1:0]  leaf_q;
	logic [KW-1:0]         ptr_q;
	logic [KW-1:0]         end_q;
	logic [VALUE_BITS-1:0] val_q;
	logic                  rd_pend_q;
	logic [SUM_BITS-1:0]   acc_q;
	logic                  out_valid_q;
	logic [SUM_BITS-1:0]   out_sum_q;

	logic [KW-1:0] lc, active, last, ql, qr, hi;
	logic          empty;
	logic [EW-1:0] sum_ext;
	logic          out_load;

	always_comb begin
		lc = KW'(leaf_q);
		if (lc == '0) begin
			active = KW'(1);
		end else if (lc > MAX_K) begin
			active = MAX_K;
		end else begin
			active = lc;
		end
		last = active - KW'(1);
		ql = KW'(req.range_left);
		qr = KW'(req.range_right);
		empty = (ql > qr) || (ql > last);
		hi = (qr > last) ? last : qr;
		sum_ext = EW'(acc_q) + EW'(mem_rdata);
		out_load = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);
	end

	// hold off requests while a leaf_count write is offered
	assign req.ready = (state_q == ST_IDLE) && !cfg.valid;
	assign cfg.ready = (state_q == ST_IDLE) || (state_q == ST_CLEAR);
	assign rsp.valid = out_valid_q;
	assign rsp.range_sum = out_sum_q;
	assign mem_we = (state_q == ST_CLEAR) || (state_q == ST_ASSIGN);
	assign mem_addr = ptr_q[AW-1:0];
	assign mem_wdata = (state_q == ST_CLEAR) ? '0 : val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			leaf_q <= LEAF_BITS'(1024);
			ptr_q <= '0;
			end_q <= '0;
			rd_pend_q <= 1'b0;
			acc_q <= '0;
			out_valid_q <= 1'b0;
			out_sum_q <= '0;
			val_q <= '0;
		end else begin
			rd_pend_q <= (state_q == ST_QUERY);
			if (rd_pend_q) begin
				acc_q <= sum_ext[SUM_BITS-1:0];
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_sum_q <= acc_q;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (cfg.valid) begin
						leaf_q <= cfg.leaf_count;
						ptr_q <= '0;
					end else if (ptr_q == MAX_K - KW'(1)) begin
						state_q <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q + KW'(1);
					end
				end
				ST_IDLE: begin
					if (cfg.valid) begin
						leaf_q <= cfg.leaf_count;
						ptr_q <= '0;
						state_q <= ST_CLEAR;
					end else if (req.valid) begin
						ptr_q <= ql;
						end_q <= hi;
						val_q <= VALUE_BITS'(req.assign_value);
						acc_q <= '0;
						if (req.req_type == REQ_QUERY) begin
							state_q <= empty ? ST_DONE : ST_QUERY;
						end else if (!empty) begin
							state_q <= ST_ASSIGN;
						end
					end
				end
				ST_ASSIGN: begin
					if (ptr_q == end_q) begin
						state_q <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q + KW'(1);
					end
				end
				ST_QUERY: begin
					if (ptr_q == end_q) begin
						state_q <= ST_DRAIN;
					end else begin
						ptr_q <= ptr_q + KW'(1);
					end
				end
				ST_DRAIN: begin
					// last read data lands in the accumulator this cycle
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ----- rtl/core/lazy_range_assign_sum_tree_top.sv -----
// ----------------------------------------------------------------------------
// lazy_range_assign_sum_tree_top
// Range assign and range sum over up to MAX_ELEMENTS unsigned elements.
// ----------------------------------------------------------------------------
//  channel  role    carries
//  req      sink    req_type, range_left, range_right, assign_value
//  rsp      source  range_sum (queries only)
//  cfg      sink    leaf_count
//
// An assign sweeps the range clipped to the active leaf count, writing
// each element; a query sums it through ST_QUERY, ST_DRAIN, ST_DONE. An
// empty assign is dropped, an empty query goes straight to ST_DONE. The
// rate is set by the element store's write and read port on one address,
// swept one index a cycle. After reset and after each leaf_count write a
// clearing pass over all MAX_ELEMENTS entries runs; no request is taken
// meanwhile, nor while a leaf_count write is offered.
// A finished query result waits in an output register while the next
// request is taken; a later query holds in its last state until that
// register is free.
module lazy_range_assign_sum_tree_top import lrast_pkg::*; #(
	parameter int MAX_ELEMENTS = 1024,
	parameter int VALUE_BITS = 32
) (
	input logic         clk,
	input logic         arst_n,
	lrast_req_if.sink   req,
	lrast_rsp_if.source rsp,
	lrast_cfg_if.sink   cfg
);
	logic                            mem_we;
	logic [$clog2(MAX_ELEMENTS)-1:0] mem_addr;
	logic [VALUE_BITS-1:0]           mem_wdata;
	logic [VALUE_BITS-1:0]           mem_rdata;

	lrast_seq #(.MAX_ELEMENTS(MAX_ELEMENTS), .VALUE_BITS(VALUE_BITS)) u_seq (
		.clk, .arst_n, .req, .rsp, .cfg,
		.mem_we, .mem_addr, .mem_wdata, .mem_rdata
	);

	lrast_mem #(.DEPTH(MAX_ELEMENTS), .WIDTH(VALUE_BITS)) u_mem (
		.clk, .we(mem_we), .waddr(mem_addr), .wdata(mem_wdata),
		.raddr(mem_addr), .rdata(mem_rdata)
	);
endmodule

// ----- rtl/core/lrast_chk.sv -----
// ----------------------------------------------------------------------------
// lrast_chk
// Port-level checks of the range assign / range sum block.
// ----------------------------------------------------------------------------
module lrast_chk import lrast_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                in_type,
	input logic                out_valid,
	input logic                out_ready,
	input logic [SUM_BITS-1:0] out_sum,
	input logic                cfg_valid,
	input logic                cfg_ready
);
	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_sum))
		else $error("result dropped or changed while stalled");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_type == REQ_QUERY |=> !in_ready)
		else $error("request taken during a query");

	a_cfg_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !in_ready)
		else $error("request taken before store cleared");
endmodule

bind lazy_range_assign_sum_tree_top lrast_chk u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(req.valid), .in_ready(req.ready), .in_type(req.req_type),
	.out_valid(rsp.valid), .out_ready(rsp.ready), .out_sum(rsp.range_sum),
	.cfg_valid(cfg.valid), .cfg_ready(cfg.ready)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks range assign and range sum against a flat array model of the
// elements, over several leaf counts, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
	import lrast_pkg::*;

	localparam int MAX_EL = 1024;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic                        kind;
		logic [INDEX_BITS-1:0]       lo;
		logic [INDEX_BITS-1:0]       hi;
		logic [FIELD_VALUE_BITS-1:0] val;
		logic                        has_sum;
		logic [SUM_BITS-1:0]         sum;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lrast_req_if req ();
	lrast_rsp_if rsp ();
	lrast_cfg_if cfg ();

	lazy_range_assign_sum_tree_top u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req.sink),
		.rsp   (rsp.sink),
		.cfg   (cfg.sink)
	);

	always #5 clk = ~clk;

	logic [FIELD_VALUE_BITS-1:0] elem [MAX_EL];
	int unsigned active_n = MAX_EL;
	logic [SUM_BITS-1:0] sum_queue [$];
	int errors = 0;
	int idle_cycles = 0;
	bit stall_on = 1'b1;

	task automatic report(input string what, input logic [SUM_BITS-1:0] got,
		input logic [SUM_BITS-1:0] want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Apply one request to the element array; return a sum for a query.
	function automatic logic [63:0] range_apply(input logic kind,
		input int unsigned lo, input int unsigned hi, input logic [31:0] val);
		logic [63:0] acc;
		int unsigned top;
		acc = '0;
		top = (hi > active_n - 1) ? active_n - 1 : hi;
		if (lo > hi || lo > active_n - 1) return '0;
		for (int unsigned i = lo; i <= top; i++) begin
			if (kind == REQ_ASSIGN) elem[i] = val;
			else acc += elem[i];
		end
		return acc;
	endfunction

	task automatic set_leaves(input logic [LEAF_BITS-1:0] n);
		cfg.valid <= 1'b1;
		cfg.leaf_count <= n;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		active_n = (n == 0) ? 1 : (n > MAX_EL ? MAX_EL : n);
		for (int i = 0; i < MAX_EL; i++) elem[i] = '0;
	endtask

	task automatic send(input logic kind, input logic [9:0] lo, input logic [9:0] hi,
		input logic [31:0] val, input logic has_sum, input logic [SUM_BITS-1:0] typed);
		logic [63:0] s;
		req.valid <= 1'b1;
		req.req_type <= kind;
		req.range_left <= lo;
		req.range_right <= hi;
		req.assign_value <= val;
		do @(posedge clk); while (!req.ready);
		s = range_apply(kind, 32'(lo), 32'(hi), val);
		if (kind == REQ_QUERY) begin
			if (has_sum && typed != s[SUM_BITS-1:0]) report("table", typed, s[SUM_BITS-1:0]);
			sum_queue = {sum_queue, s[SUM_BITS-1:0]};
		end
	endtask

	// Now and then drop valid for a random gap.
	task automatic gap();
		int n;
		n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0;
		if (n > 0) begin
			req.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (sum_queue.size() != 0) @(posedge clk);
		repeat (MAX_EL + 20) @(posedge clk);
	endtask

	task automatic random_req(input int unsigned span);
		logic kind;
		int unsigned lo, hi;
		logic [31:0] val;
		kind = 1'($urandom_range(0, 1));
		lo = $urandom_range(0, span);
		hi = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
			: lo + $urandom_range(0, 40);
		if (hi > 1023) hi = 1023;
		if ($urandom_range(0, 15) == 0) lo = $urandom_range(0, 1023);
		val = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : $urandom();
		send(kind, 10'(lo), 10'(hi), val, 1'b0, '0);
		gap();
	endtask

	// Check results, keep the stall pattern and run the idle watchdog.
	always @(posedge clk) begin
		if (rsp.valid && rsp.ready) begin
			if (sum_queue.size() == 0) report("unexpected", rsp.range_sum, '0);
			else begin
				if (rsp.range_sum != sum_queue[0]) report("sum", rsp.range_sum, sum_queue[0]);
				void'(sum_queue.pop_front());
			end
		end
		if ($urandom_range(0, 63) == 0) stall_on <= ~stall_on;
		rsp.ready <= stall_on ? ($urandom_range(0, 2) != 0) : 1'b1;
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	row_t dir_rows [] = '{
		'{REQ_QUERY, 10'd0, 10'd1023, 32'd0, 1'b1, 42'd0},
		'{REQ_ASSIGN, 10'd0, 10'd1023, 32'hFFFF_FFFF, 1'b0, 42'd0},
		'{REQ_QUERY, 10'd0, 10'd1023, 32'd0, 1'b1, 42'd1024 * 42'hFFFF_FFFF},
		'{REQ_QUERY, 10'd5, 10'd4, 32'd0, 1'b1, 42'd0},
		'{REQ_ASSIGN, 10'd9, 10'd3, 32'd7, 1'b0, 42'd0},
		'{REQ_ASSIGN, 10'd3, 10'd3, 32'd7, 1'b0, 42'd0},
		'{REQ_QUERY, 10'd3, 10'd3, 32'd0, 1'b1, 42'd7},
		'{REQ_ASSIGN, 10'd0, 10'd0, 32'd0, 1'b0, 42'd0},
		'{REQ_QUERY, 10'd1023, 10'd1023, 32'd0, 1'b1, 42'hFFFF_FFFF},
		'{REQ_ASSIGN, 10'd100, 10'd611, 32'h5555_AAAA, 1'b0, 42'd0},
		'{REQ_QUERY, 10'd0, 10'd1023, 32'd0, 1'b0, 42'd0},
		'{REQ_QUERY, 10'd612, 10'd612, 32'd0, 1'b0, 42'd0}
	};

	row_t small_rows [] = '{
		'{REQ_ASSIGN, 10'd0, 10'd1023, 32'd9, 1'b0, 42'd0},
		'{REQ_QUERY, 10'd0, 10'd1023, 32'd0, 1'b0, 42'd0},
		'{REQ_QUERY, 10'd1, 10'd1023, 32'd0, 1'b1, 42'd0},
		'{REQ_ASSIGN, 10'd1023, 10'd1023, 32'd3, 1'b0, 42'd0},
		'{REQ_QUERY, 10'd0, 10'd0, 32'd0, 1'b0, 42'd0}
	};

	initial begin
		req.valid = 1'b0;
		req.req_type = REQ_ASSIGN;
		req.range_left = '0;
		req.range_right = '0;
		req.assign_value = '0;
		rsp.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.leaf_count = '0;
		for (int i = 0; i < MAX_EL; i++) elem[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send(dir_rows[i].kind, dir_rows[i].lo, dir_rows[i].hi, dir_rows[i].val,
				dir_rows[i].has_sum, dir_rows[i].sum);
		drain();
		set_leaves(11'd0);
		foreach (small_rows[i])
			send(small_rows[i].kind, small_rows[i].lo, small_rows[i].hi, small_rows[i].val,
				small_rows[i].has_sum, small_rows[i].sum);
		repeat (40) random_req(3);
		drain();
		set_leaves(11'd2047);
		repeat (150) random_req(1023);
		drain();
		set_leaves(11'd37);
		repeat (300) random_req(45);
		drain();
		set_leaves(11'd1);
		repeat (40) random_req(2);
		drain();
		set_leaves(11'd200);
		repeat (300) random_req(220);
		drain();
		set_leaves(11'd1024);
		repeat (70) random_req(1023);
		drain();

		if (errors == 0) $display("tb_top: PASS");
		else $display("tb_top: FAIL");
		$finish;
	end
endmodule
